>>> rtl/hcts_pkg.sv
// shared types, constants and byte classification for the hex colour token scanner
package hcts_pkg;

	localparam int unsigned THRESH_W = 26;
	localparam int unsigned POS_W    = 32;
	localparam int unsigned SQ_W     = 16;
	localparam int unsigned WEIGHT_W = 10;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 26'd16256250;

	// brightness weights in thousandths
	localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 10'd299;
	localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 10'd587;
	localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 10'd114;

	localparam logic [7:0] CHAR_HASH = 8'h23;

	localparam logic [1:0] KIND_RGB      = 2'd0;
	localparam logic [1:0] KIND_RGBA     = 2'd1;
	localparam logic [1:0] KIND_RRGGBB   = 2'd2;
	localparam logic [1:0] KIND_RRGGBBAA = 2'd3;

	localparam logic [1:0] COMP_RED   = 2'd0;
	localparam logic [1:0] COMP_GREEN = 2'd1;
	localparam logic [1:0] COMP_BLUE  = 2'd2;

	localparam logic [2:0] LAST_STEP = 3'd5;

	typedef enum logic [1:0] {
		ST_SCAN,
		ST_CALC,
		ST_HOLD
	} hcts_state_t;

	typedef struct packed {
		logic       scan_en;
		logic       clr_acc;
		logic       sq_en;
		logic       acc_en;
		logic [1:0] comp_sel;
		logic       load_out;
	} hcts_cmd_t;

	typedef struct packed {
		logic close_valid;
	} hcts_status_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// five bits: values 0..15 for hex digits, 16 for anything else
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h37);
		end
		return v;
	endfunction

endpackage

>>> rtl/hcts_ifs.sv
// valid/ready channel interfaces for text bytes and colour results
interface hcts_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       stream_end;

	modport source (output valid, output text_byte, output stream_end, input ready);
	modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

interface hcts_color_if;
	logic        valid;
	logic        ready;
	logic [1:0]  color_kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        is_bright;
	logic [31:0] token_offset;

	modport source (output valid, output color_kind, output red, output green,
		output blue, output is_bright, output token_offset, input ready);
	modport sink   (input valid, input color_kind, input red, input green,
		input blue, input is_bright, input token_offset, output ready);
endinterface

>>> rtl/hcts_ctrl.sv
// controller: scan, brightness sequence and output register handshake
module hcts_ctrl
	import hcts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         text_valid,
	output logic         text_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  hcts_status_t status,
	output hcts_cmd_t    cmd
);

	hcts_state_t state_q, state_d;
	logic [2:0]  step_q, step_d;
	logic        out_valid_q, out_valid_d;
	logic        out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		text_ready   = 1'b0;
		cmd          = '0;
		cmd.comp_sel = step_q[2:1];
		case (state_q)
			ST_SCAN: begin
				text_ready  = 1'b1;
				cmd.scan_en = text_valid;
				if (text_valid && status.close_valid) begin
					cmd.clr_acc = 1'b1;
					step_d      = '0;
					state_d     = ST_CALC;
				end
			end
			ST_CALC: begin
				// even steps square a component, odd steps weight and add it
				cmd.sq_en  = !step_q[0];
				cmd.acc_en = step_q[0];
				step_d     = 3'(step_q + 3'd1);
				if (step_q == LAST_STEP) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end
	end

endmodule

>>> rtl/hcts_datapath.sv
// datapath: per-byte token state, digit store, brightness multiplier and result register
module hcts_datapath
	import hcts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	input  logic [7:0]          text_byte,
	input  logic                stream_end,
	input  hcts_cmd_t           cmd,
	output hcts_status_t        status,
	output logic [1:0]          color_kind,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic                is_bright,
	output logic [POS_W-1:0]    token_offset
);

	logic [THRESH_W-1:0] thresh_q;
	logic                in_token_q, prev_alnum_q, all_hex_q;
	logic [3:0]          run_len_q;
	logic [POS_W-1:0]    pos_q, start_q;
	logic [3:0]          digit_q [8];
	logic [1:0]          kind_q;
	logic [SQ_W-1:0]     sq_q;
	logic [THRESH_W-1:0] acc_q;

	logic                alnum;
	logic [4:0]          hval;
	logic                tok_mid, hex_mid, start_tok, close_ev, len_ok, wr_digit;
	logic [3:0]          len_mid;
	logic [1:0]          kind_mid;
	logic [7:0]          comp_r, comp_g, comp_b, comp;
	logic [WEIGHT_W-1:0] weight;

	assign alnum = is_alnum(text_byte);
	assign hval  = hex_value(text_byte);

	// token state after the byte, before the end-of-stream close
	always_comb begin
		tok_mid  = in_token_q;
		hex_mid  = all_hex_q;
		len_mid  = run_len_q;
		wr_digit = 1'b0;
		close_ev = 1'b0;
		if (in_token_q) begin
			if (alnum) begin
				hex_mid  = all_hex_q && !hval[4];
				wr_digit = !run_len_q[3];
				if (run_len_q != 4'd9) begin
					len_mid = 4'(run_len_q + 4'd1);
				end
			end else begin
				close_ev = 1'b1;
				tok_mid  = 1'b0;
			end
		end
		start_tok = !tok_mid && (text_byte == CHAR_HASH) && !prev_alnum_q;
		if (start_tok) begin
			tok_mid = 1'b1;
			hex_mid = 1'b1;
			len_mid = '0;
		end
		if (stream_end && tok_mid) begin
			close_ev = 1'b1;
		end
	end

	always_comb begin
		len_ok   = 1'b1;
		kind_mid = KIND_RGB;
		case (len_mid)
			4'd3:    kind_mid = KIND_RGB;
			4'd4:    kind_mid = KIND_RGBA;
			4'd6:    kind_mid = KIND_RRGGBB;
			4'd8:    kind_mid = KIND_RRGGBBAA;
			default: len_ok   = 1'b0;
		endcase
	end

	assign status.close_valid = close_ev && hex_mid && len_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= THRESH_RESET;
			in_token_q   <= 1'b0;
			prev_alnum_q <= 1'b0;
			all_hex_q    <= 1'b1;
			run_len_q    <= '0;
			pos_q        <= '0;
			start_q      <= '0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (cmd.scan_en) begin
				all_hex_q <= hex_mid;
				run_len_q <= len_mid;
				if (start_tok) begin
					start_q <= pos_q;
				end
				if (stream_end) begin
					in_token_q   <= 1'b0;
					prev_alnum_q <= 1'b0;
					pos_q        <= '0;
				end else begin
					// a hash that closes an empty run opens the next token
					in_token_q   <= tok_mid;
					prev_alnum_q <= alnum;
					pos_q        <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en && wr_digit) begin
			digit_q[run_len_q[2:0]] <= hval[3:0];
		end
		if (cmd.scan_en && status.close_valid) begin
			kind_q <= kind_mid;
		end
	end

	// short forms repeat each digit
	always_comb begin
		if (kind_q[1]) begin
			comp_r = {digit_q[0], digit_q[1]};
			comp_g = {digit_q[2], digit_q[3]};
			comp_b = {digit_q[4], digit_q[5]};
		end else begin
			comp_r = {digit_q[0], digit_q[0]};
			comp_g = {digit_q[1], digit_q[1]};
			comp_b = {digit_q[2], digit_q[2]};
		end
	end

	always_comb begin
		case (cmd.comp_sel)
			COMP_RED: begin
				comp   = comp_r;
				weight = WEIGHT_RED;
			end
			COMP_GREEN: begin
				comp   = comp_g;
				weight = WEIGHT_GREEN;
			end
			COMP_BLUE: begin
				comp   = comp_b;
				weight = WEIGHT_BLUE;
			end
			default: begin
				comp   = '0;
				weight = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sq_q <= SQ_W'(comp) * SQ_W'(comp);
		end
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + THRESH_W'(sq_q) * THRESH_W'(weight);
		end
		if (cmd.load_out) begin
			color_kind   <= kind_q;
			red          <= comp_r;
			green        <= comp_g;
			blue         <= comp_b;
			is_bright    <= acc_q > thresh_q;
			token_offset <= start_q;
		end
	end

endmodule

>>> rtl/hex_color_token_scanner.sv
// hex colour token scanner: finds #rgb, #rgba, #rrggbb and #rrggbbaa tokens in a byte stream
//
// text channel: one stream byte a beat, stream_end marks the last byte of a stream.
// color channel: one beat for each valid token, giving kind, red, green, blue,
// the brightness flag and the stream position of the hash.
// cfg_we/cfg_wdata write the brightness threshold (thousandths, 26 bits).
// ordinary text streams at one byte a cycle except after the byte that closes a
// valid token, which is followed by a brightness pass on one shared multiplier
// (square, then weight and add, per component) and a load of the result
// register, which waits while the output register still holds an untaken result:
// the text channel is held off until the result register is loaded.
// the result sits in an output register: scanning goes on while it waits,
// and only a further valid token waits for the receiver to take it.
// reset clears the token state, the byte position and the output valid and
// reloads the threshold with its default.
module hex_color_token_scanner
	import hcts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	hcts_text_if.sink           text,
	hcts_color_if.source        color
);

	hcts_cmd_t    cmd;
	hcts_status_t status;

	hcts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text.valid),
		.text_ready (text.ready),
		.out_valid  (color.valid),
		.out_ready  (color.ready),
		.status     (status),
		.cmd        (cmd)
	);

	hcts_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.text_byte    (text.text_byte),
		.stream_end   (text.stream_end),
		.cmd          (cmd),
		.status       (status),
		.color_kind   (color.color_kind),
		.red          (color.red),
		.green        (color.green),
		.blue         (color.blue),
		.is_bright    (color.is_bright),
		.token_offset (color.token_offset)
	);

endmodule
